/* hdl/cprs_pkg.sv */
package cprs_pkg;

    localparam int MaxRanges    = 32;
    localparam int MaxCodePoint = 1114111;
    localparam int CodeW        = 21;
    localparam int IdxW         = $clog2(MaxRanges);
    localparam int CntW         = $clog2(MaxRanges + 1);
    localparam int EntryW       = 2 * CodeW;

    typedef enum logic [2:0] {
        KIND_ADD       = 3'd0,
        KIND_REMOVE    = 3'd1,
        KIND_INTERSECT = 3'd2,
        KIND_COMPL     = 3'd3,
        KIND_QUERY     = 3'd4,
        KIND_READ      = 3'd5,
        KIND_CLEAR     = 3'd6,
        KIND_NONE      = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_TAIL,
        ST_COPY,
        ST_DONE
    } state_t;

endpackage

/* hdl/cprs_ram.sv */
module cprs_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/code_point_range_set_unit.sv */
// Steps: read entry goes accept, table read, result; query scans the table,
// one table entry a cycle, stopping after a hit or at the last entry; clear
// and the unknown kind go straight from accept to result.
// Add, remove, intersect, complement run a scan pass reading one entry per
// cycle (stalled while a step that emits two ranges writes its second), a tail step,
// then a copy pass of the rebuilt table from the scratch RAM back to the live
// RAM. The copy pass is skipped when the result is empty or overflows.
// One item at a time: a new item is accepted only in the idle state.
// Reset: count cleared (empty set); RAM contents are not cleared.
module code_point_range_set_unit
    import cprs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] kind, [23:3] first_code, [44:24] last_code, [49:45] entry_index
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] is_member, [1] entry_valid, [22:2] range_first, [43:23] range_last,
    // [49:44] range_count, [50] overflow
    output logic [55:0] m_tdata
);

    state_t state_reg, state_next;

    logic [2:0]       kind_reg;
    logic [CodeW-1:0] a_reg, b_reg;      // operand, clamped and ordered
    logic [CodeW-1:0] code_reg;          // raw queried code point
    logic [IdxW-1:0]  idx_reg;
    logic [CntW-1:0]  used_reg;
    logic [CntW-1:0]  pos_reg;           // scan / copy position
    logic [8:0]       ncnt_reg;          // emitted count, may exceed max
    logic             placed_reg;
    logic [CodeW:0]   cursor_reg;        // complement cursor, may be max+1
    logic             hit_reg;

    logic             om_reg, ov_reg, oovf_reg;
    logic [CodeW-1:0] of_reg, ol_reg;
    logic             m_valid_reg;

    // live table RAM and scratch RAM
    logic              t_we;
    logic [IdxW-1:0]   t_waddr, t_raddr;
    logic [EntryW-1:0] t_wdata, t_rdata;
    logic              n_we;
    logic [IdxW-1:0]   n_waddr, n_raddr;
    logic [EntryW-1:0] n_wdata, n_rdata;

    cprs_ram #(.Width(EntryW), .Depth(MaxRanges)) u_table (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );
    cprs_ram #(.Width(EntryW), .Depth(MaxRanges)) u_scratch (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    logic [CodeW-1:0] in_a, in_b, ca, cb;
    assign in_a = s_tdata[23:3];
    assign in_b = s_tdata[44:24];
    assign ca = (in_a > CodeW'(MaxCodePoint)) ? CodeW'(MaxCodePoint) : in_a;
    assign cb = (in_b > CodeW'(MaxCodePoint)) ? CodeW'(MaxCodePoint) : in_b;

    logic [CodeW-1:0] s_cur, e_cur;
    assign s_cur = t_rdata[CodeW-1:0];
    assign e_cur = t_rdata[EntryW-1:CodeW];

    logic scan_last;   // pos_reg is the entry whose data arrives now
    assign scan_last = (pos_reg + CntW'(1)) >= used_reg;

    // per-entry emission: up to two ranges per scan step
    logic             em0, em1;
    logic [CodeW-1:0] e0s, e0e, e1s, e1e;
    logic [CodeW-1:0] a_new, b_new;
    logic             placed_new;
    logic [CodeW:0]   cursor_new;
    logic [CodeW:0]   e_p1, b_p1;

    assign e_p1 = {1'b0, e_cur} + (CodeW+1)'(1);
    assign b_p1 = {1'b0, b_reg} + (CodeW+1)'(1);

    always_comb
    begin
        em0 = 1'b0; em1 = 1'b0;
        e0s = s_cur; e0e = e_cur; e1s = s_cur; e1e = e_cur;
        a_new = a_reg; b_new = b_reg;
        placed_new = placed_reg;
        cursor_new = cursor_reg;
        case (kind_reg)
            KIND_ADD:
            begin
                if (e_p1 < {1'b0, a_reg})
                begin
                    em0 = 1'b1;
                end
                else if ({1'b0, s_cur} > b_p1)
                begin
                    if (!placed_reg)
                    begin
                        em0 = 1'b1; e0s = a_reg; e0e = b_reg;
                        em1 = 1'b1;
                        placed_new = 1'b1;
                    end
                    else
                    begin
                        em0 = 1'b1;
                    end
                end
                else
                begin
                    if (s_cur < a_reg) a_new = s_cur;
                    if (e_cur > b_reg) b_new = e_cur;
                end
            end
            KIND_REMOVE:
            begin
                if (e_cur < a_reg || s_cur > b_reg)
                begin
                    em0 = 1'b1;
                end
                else
                begin
                    if (s_cur < a_reg)
                    begin
                        em0 = 1'b1; e0e = a_reg - CodeW'(1);
                    end
                    if (e_cur > b_reg)
                    begin
                        em1 = 1'b1; e1s = b_reg + CodeW'(1);
                    end
                end
            end
            KIND_INTERSECT:
            begin
                e0s = (s_cur > a_reg) ? s_cur : a_reg;
                e0e = (e_cur < b_reg) ? e_cur : b_reg;
                em0 = (e0s <= e0e);
            end
            KIND_COMPL:
            begin
                if ({1'b0, s_cur} > cursor_reg)
                begin
                    em0 = 1'b1;
                    e0s = cursor_reg[CodeW-1:0];
                    e0e = s_cur - CodeW'(1);
                end
                cursor_new = e_p1;
            end
            default: ;
        endcase
    end

    // scratch writes; second emission of a step goes in the same cycle?
    // one write port only, so em1 is held over as a pending entry
    logic             pend_reg;
    logic [CodeW-1:0] ps_reg, pe_reg;

    // final emitted count once the tail range is in
    logic             tail_em;
    logic [8:0]       ncnt_fin;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid && s_tready)
                begin
                    case (kind_t'(s_tdata[2:0]))
                        KIND_ADD, KIND_REMOVE, KIND_INTERSECT, KIND_COMPL,
                        KIND_QUERY, KIND_READ:
                            state_next = ST_READ;
                        default: state_next = ST_DONE;
                    endcase
                end
            ST_READ:
                if (kind_reg == KIND_READ)
                    state_next = ST_DONE;
                else if (used_reg == '0)
                    state_next = (kind_reg == KIND_QUERY) ? ST_DONE : ST_TAIL;
                else
                    state_next = ST_SCAN;
            ST_SCAN:
                if (pend_reg)
                    state_next = ST_SCAN;
                else if (kind_reg == KIND_QUERY && (hit_reg || scan_last))
                    state_next = ST_DONE;
                else if (scan_last)
                    state_next = ST_TAIL;
            ST_TAIL:
                if (!pend_reg)
                    state_next = (ncnt_fin > 9'(MaxRanges) || ncnt_fin == '0)
                                 ? ST_DONE : ST_COPY;
            ST_COPY:
                if (pos_reg == ncnt_reg[CntW-1:0])
                    state_next = ST_DONE;
            ST_DONE:
                if (m_tready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // query hit on current entry
    logic hit_now;
    assign hit_now = (code_reg >= s_cur) && (code_reg <= e_cur);

    // scratch write selection
    logic             w_en;
    logic [CodeW-1:0] w_s, w_e;
    logic [CodeW-1:0] tail_s, tail_e;

    always_comb
    begin
        tail_em = 1'b0;
        tail_s = a_reg; tail_e = b_reg;
        if (kind_reg == KIND_ADD)
        begin
            tail_em = !placed_reg;
        end
        else if (kind_reg == KIND_COMPL)
        begin
            tail_em = cursor_reg <= (CodeW+1)'(MaxCodePoint);
            tail_s = cursor_reg[CodeW-1:0];
            tail_e = CodeW'(MaxCodePoint);
        end
    end

    assign ncnt_fin = ncnt_reg + 9'(tail_em);

    always_comb
    begin
        w_en = 1'b0; w_s = e0s; w_e = e0e;
        if (state_reg == ST_SCAN || state_reg == ST_TAIL)
        begin
            if (pend_reg)
            begin
                w_en = 1'b1; w_s = ps_reg; w_e = pe_reg;
            end
            else if (state_reg == ST_SCAN && kind_reg != KIND_QUERY)
            begin
                if (em0)
                begin
                    w_en = 1'b1;
                end
                else if (em1)
                begin
                    w_en = 1'b1; w_s = e1s; w_e = e1e;
                end
            end
            else if (state_reg == ST_TAIL)
            begin
                w_en = tail_em; w_s = tail_s; w_e = tail_e;
            end
        end
    end

    assign n_we    = w_en && (ncnt_reg < 9'(MaxRanges));
    assign n_waddr = ncnt_reg[IdxW-1:0];
    assign n_wdata = {w_e, w_s};
    assign n_raddr = pos_reg[IdxW-1:0];

    // table read: entry index presented with the accepted item, scan
    // position otherwise; a pending write stalls the scan, so keep address
    // steady then
    always_comb
    begin
        t_raddr = pos_reg[IdxW-1:0];
        if (state_reg == ST_IDLE)
            t_raddr = s_tdata[49:45];
        else if (state_reg == ST_SCAN && !pend_reg)
            t_raddr = pos_reg[IdxW-1:0] + IdxW'(1);
    end

    // copy: scratch data for pos-1 arrives when pos>0
    assign t_we    = (state_reg == ST_COPY) && (pos_reg != '0);
    assign t_waddr = pos_reg[IdxW-1:0] - IdxW'(1);
    assign t_wdata = n_rdata;

    logic tail_stall; // pending entry still to go before tail write
    assign tail_stall = pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                    if (s_tvalid)
                    begin
                        pend_reg <= 1'b0;
                        if (s_tdata[2:0] == KIND_CLEAR)
                            used_reg <= '0;
                    end
                ST_SCAN:
                    if (pend_reg)
                        pend_reg <= 1'b0;
                    else
                        pend_reg <= (kind_reg != KIND_QUERY) && em0 && em1;
                ST_TAIL:
                    if (tail_stall)
                        pend_reg <= 1'b0;
                ST_COPY:
                    if (pos_reg == ncnt_reg[CntW-1:0])
                        used_reg <= ncnt_reg[CntW-1:0];
                default: ;
            endcase
            if (state_reg == ST_TAIL && !tail_stall && state_next == ST_DONE
                && ncnt_fin == '0)
                used_reg <= '0;
            if (state_next == ST_DONE && state_reg != ST_DONE)
                m_valid_reg <= 1'b1;
            else if (state_reg == ST_DONE && m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                begin
                    kind_reg   <= s_tdata[2:0];
                    a_reg      <= (ca > cb) ? cb : ca;
                    b_reg      <= (ca > cb) ? ca : cb;
                    code_reg   <= in_a;
                    idx_reg    <= s_tdata[49:45];
                    pos_reg    <= '0;
                    ncnt_reg   <= '0;
                    placed_reg <= 1'b0;
                    cursor_reg <= '0;
                    hit_reg    <= 1'b0;
                    om_reg     <= 1'b0;
                    ov_reg     <= 1'b0;
                    of_reg     <= '0;
                    ol_reg     <= '0;
                    oovf_reg   <= 1'b0;
                end
            ST_READ:
                if (kind_reg == KIND_READ && {1'b0, idx_reg} < used_reg)
                begin
                    ov_reg <= 1'b1;
                    of_reg <= s_cur;
                    ol_reg <= e_cur;
                end
            ST_SCAN:
            begin
                if (pend_reg)
                begin
                    ncnt_reg <= ncnt_reg + 9'(1);
                end
                else if (kind_reg == KIND_QUERY)
                begin
                    if (hit_now)
                    begin
                        hit_reg <= 1'b1;
                        om_reg  <= 1'b1;
                    end
                    pos_reg <= pos_reg + CntW'(1);
                end
                else
                begin
                    if (em0 || em1)
                        ncnt_reg <= ncnt_reg + 9'(1);
                    ps_reg     <= e1s;
                    pe_reg     <= e1e;
                    a_reg      <= a_new;
                    b_reg      <= b_new;
                    placed_reg <= placed_new;
                    cursor_reg <= cursor_new;
                    pos_reg    <= scan_last ? '0 : pos_reg + CntW'(1);
                end
            end
            ST_TAIL:
                if (tail_stall)
                begin
                    ncnt_reg <= ncnt_reg + 9'(1);
                end
                else
                begin
                    pos_reg <= '0;
                    if (ncnt_fin > 9'(MaxRanges))
                    begin
                        oovf_reg <= 1'b1;
                        ncnt_reg <= 9'(MaxRanges) + 9'(1);
                    end
                    else
                        ncnt_reg <= ncnt_fin;
                end
            ST_COPY:
                pos_reg <= pos_reg + CntW'(1);
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, oovf_reg, used_reg, ol_reg, of_reg, ov_reg, om_reg};

endmodule
